[design/mck_pkg.sv]
// package: shared types, constants, symbol table and control store of the morse keyer
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    // ascii codes that bound the symbol classes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam int LETTER_COUNT = 26;
    localparam int MAX_ELEMS    = 5;

    // opcodes of an input item
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOM  = 1'b1;

    // segment durations in morse units
    localparam logic [2:0] UNITS_DOT     = 3'd1;
    localparam logic [2:0] UNITS_DASH    = 3'd3;
    localparam logic [2:0] UNITS_ELEMGAP = 3'd1;
    localparam logic [2:0] UNITS_LETTER  = 3'd2;
    localparam logic [2:0] UNITS_WORD    = 3'd6;
    localparam logic [2:0] UNITS_MESSAGE = 3'd7;

    // microprogram step addresses
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_ON    = 3'd1;
    localparam step_t STEP_OFF   = 3'd2;
    localparam step_t STEP_GAP   = 3'd3;
    localparam step_t STEP_SPACE = 3'd4;
    localparam step_t STEP_EOM   = 3'd5;

    // next-step selection
    typedef enum logic [1:0] {
        JMP_SEQ      = 2'd0,   // step + 1
        JMP_ABS      = 2'd1,   // jump to target
        JMP_LOOP     = 2'd2,   // to target while elements remain, else step + 1
        JMP_DISPATCH = 2'd3    // branch on the class of the incoming item
    } jmp_t;

    // source of the segment duration
    typedef enum logic {
        USEL_CONST = 1'b0,
        USEL_ELEM  = 1'b1
    } usel_t;

    // one control word
    typedef struct packed {
        logic        take_in;
        logic        emit;
        logic        level;
        usel_t       units_sel;
        logic [2:0]  units;
        logic        last;
        logic        shift;
        jmp_t        jmp;
        step_t       target;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic is_eom;
        logic is_space;
        logic has_code;
        logic more;
        logic out_free;
    } stat_t;

    // element pattern: first element at the msb, 1 = dash
    typedef struct packed {
        logic [2:0]           len;
        logic [MAX_ELEMS-1:0] pat;
    } sym_t;

    // control store
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c = '{take_in: 1'b0, emit: 1'b0, level: 1'b0, units_sel: USEL_CONST,
              units: 3'd0, last: 1'b0, shift: 1'b0, jmp: JMP_ABS, target: STEP_IDLE};
        unique case (s)
            STEP_IDLE:
            begin
                c.take_in = 1'b1;
                c.jmp     = JMP_DISPATCH;
            end
            STEP_ON:
            begin
                c.emit      = 1'b1;
                c.level     = 1'b1;
                c.units_sel = USEL_ELEM;
                c.jmp       = JMP_SEQ;
            end
            STEP_OFF:
            begin
                c.emit   = 1'b1;
                c.units  = UNITS_ELEMGAP;
                c.shift  = 1'b1;
                c.jmp    = JMP_LOOP;
                c.target = STEP_ON;
            end
            STEP_GAP:
            begin
                c.emit  = 1'b1;
                c.units = UNITS_LETTER;
                c.last  = 1'b1;
            end
            STEP_SPACE:
            begin
                c.emit  = 1'b1;
                c.units = UNITS_WORD;
                c.last  = 1'b1;
            end
            STEP_EOM:
            begin
                c.emit  = 1'b1;
                c.units = UNITS_MESSAGE;
                c.last  = 1'b1;
            end
            default:
            begin
                c.jmp = JMP_ABS;
            end
        endcase
        return c;
    endfunction

    // international morse table, letters a-z then digits 0-9
    function automatic sym_t sym_code(input logic [5:0] idx);
        sym_t r;
        unique case (idx)
            6'd0:  r = '{3'd2, 5'b01000};
            6'd1:  r = '{3'd4, 5'b10000};
            6'd2:  r = '{3'd4, 5'b10100};
            6'd3:  r = '{3'd3, 5'b10000};
            6'd4:  r = '{3'd1, 5'b00000};
            6'd5:  r = '{3'd4, 5'b00100};
            6'd6:  r = '{3'd3, 5'b11000};
            6'd7:  r = '{3'd4, 5'b00000};
            6'd8:  r = '{3'd2, 5'b00000};
            6'd9:  r = '{3'd4, 5'b01110};
            6'd10: r = '{3'd3, 5'b10100};
            6'd11: r = '{3'd4, 5'b01000};
            6'd12: r = '{3'd2, 5'b11000};
            6'd13: r = '{3'd2, 5'b10000};
            6'd14: r = '{3'd3, 5'b11100};
            6'd15: r = '{3'd4, 5'b01100};
            6'd16: r = '{3'd4, 5'b11010};
            6'd17: r = '{3'd3, 5'b01000};
            6'd18: r = '{3'd3, 5'b00000};
            6'd19: r = '{3'd1, 5'b10000};
            6'd20: r = '{3'd3, 5'b00100};
            6'd21: r = '{3'd4, 5'b00010};
            6'd22: r = '{3'd3, 5'b01100};
            6'd23: r = '{3'd4, 5'b10010};
            6'd24: r = '{3'd4, 5'b10110};
            6'd25: r = '{3'd4, 5'b11000};
            6'd26: r = '{3'd5, 5'b11111};
            6'd27: r = '{3'd5, 5'b01111};
            6'd28: r = '{3'd5, 5'b00111};
            6'd29: r = '{3'd5, 5'b00011};
            6'd30: r = '{3'd5, 5'b00001};
            6'd31: r = '{3'd5, 5'b00000};
            6'd32: r = '{3'd5, 5'b10000};
            6'd33: r = '{3'd5, 5'b11000};
            6'd34: r = '{3'd5, 5'b11100};
            6'd35: r = '{3'd5, 5'b11110};
            default: r = '{3'd0, 5'b00000};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[design/mck_if.sv]
// interfaces: character input channel and keying segment output channel
`timescale 1ns / 1ps
`default_nettype none

interface mck_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface mck_out_if;
    logic       valid;
    logic       ready;
    logic       level;
    logic [2:0] units;
    logic       last;

    modport source (output valid, output level, output units, output last, input ready);
    modport sink   (input valid, input level, input units, input last, output ready);
endinterface

`default_nettype wire

[design/mck_useq.sv]
// microcode sequencer: step counter, control store lookup and jump logic
`timescale 1ns / 1ps
`default_nettype none

module mck_useq
    import mck_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire stat_t stat,
    output ctrl_t      ctrl,
    output logic       fire
);

    step_t step_reg;
    step_t step_next;

    // current control word
    assign ctrl = ucode(step_reg);

    // a step completes when its transfer can happen
    always_comb
    begin
        if (ctrl.emit)
        begin
            fire = stat.out_free;
        end
        else if (ctrl.take_in)
        begin
            fire = in_valid;
        end
        else
        begin
            fire = 1'b1;
        end
    end

    // next step address
    always_comb
    begin
        step_next = step_reg;
        if (fire)
        begin
            unique case (ctrl.jmp)
                JMP_SEQ:
                begin
                    step_next = step_reg + 3'd1;
                end
                JMP_ABS:
                begin
                    step_next = ctrl.target;
                end
                JMP_LOOP:
                begin
                    step_next = stat.more ? ctrl.target : step_reg + 3'd1;
                end
                JMP_DISPATCH:
                begin
                    priority if (stat.is_eom)
                    begin
                        step_next = STEP_EOM;
                    end
                    else if (stat.is_space)
                    begin
                        step_next = STEP_SPACE;
                    end
                    else if (stat.has_code)
                    begin
                        step_next = STEP_ON;
                    end
                    else
                    begin
                        step_next = STEP_GAP;
                    end
                end
                default:
                begin
                    step_next = STEP_IDLE;
                end
            endcase
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[design/mck_dpath.sv]
// datapath: character decode, element shift register and output register
`timescale 1ns / 1ps
`default_nettype none

module mck_dpath
    import mck_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_t      ctrl,
    input  wire logic       fire,
    input  wire logic       opcode,
    input  wire logic [7:0] char_code,
    input  wire logic       out_ready,
    output stat_t           stat,
    output logic            out_valid,
    output logic            out_level,
    output logic [2:0]      out_units,
    output logic            out_last
);

    logic [MAX_ELEMS-1:0] pat_reg;
    logic [MAX_ELEMS-1:0] pat_next;
    logic [2:0]           cnt_reg;
    logic [2:0]           cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 level_reg;
    logic [2:0]           units_reg;
    logic                 last_reg;

    logic                 is_upper;
    logic                 is_lower;
    logic                 is_digit;
    logic [5:0]           sym_idx;
    sym_t                 sym;
    logic                 load_out;
    logic [2:0]           seg_units;

    // classify the incoming character and form its table index
    always_comb
    begin
        is_upper = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
        is_lower = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z);
        is_digit = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
        priority if (is_upper)
        begin
            sym_idx = 6'(char_code - CH_UPPER_A);
        end
        else if (is_lower)
        begin
            sym_idx = 6'(char_code - CH_LOWER_A);
        end
        else
        begin
            sym_idx = 6'(char_code - CH_DIGIT_0) + 6'(LETTER_COUNT);
        end
        sym = sym_code(sym_idx);
    end

    // status toward the sequencer
    assign stat.is_eom   = (opcode == OP_EOM);
    assign stat.is_space = (char_code == CH_SPACE);
    assign stat.has_code = is_upper || is_lower || is_digit;
    assign stat.more     = (cnt_reg != 3'd1);
    assign stat.out_free = !out_valid_reg || out_ready;

    // element pattern and remaining count
    always_comb
    begin
        pat_next = pat_reg;
        cnt_next = cnt_reg;
        if (fire && ctrl.take_in)
        begin
            pat_next = sym.pat;
            cnt_next = sym.len;
        end
        else if (fire && ctrl.shift)
        begin
            pat_next = {pat_reg[MAX_ELEMS-2:0], 1'b0};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
        cnt_reg <= cnt_next;
    end

    // segment output register
    assign load_out  = fire && ctrl.emit;
    assign seg_units = (ctrl.units_sel == USEL_ELEM)
                     ? (pat_reg[MAX_ELEMS-1] ? UNITS_DASH : UNITS_DOT)
                     : ctrl.units;

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            level_reg <= ctrl.level;
            units_reg <= seg_units;
            last_reg  <= ctrl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = level_reg;
    assign out_units = units_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[design/morse_code_keyer.sv]
// International Morse code keyer.
// item: one transfer per character (opcode 0, ascii in char_code) or end
//   of message (opcode 1). seg: one transfer per keying segment with line
//   level, duration in morse units and a last flag on the item's final one.
// A dot is on 1 / off 1, a dash on 3 / off 1, then every non-space
// character ends with off 2; unknown codes give only off 2. Space gives
// off 6, end of message off 7.
// Sequencing: a microcoded sequencer walks a six-step control store, one
// step per cycle while no step waits on the item or segment channel. The
// item is taken in the idle step; each segment then takes one step. The
// first segment is loaded by the step after the idle step, once the
// segment register is free, and is valid when that register is loaded.
// The segment register holds its value while seg.ready is low and the
// sequencer waits on the emitting step; item.ready is high only in the
// idle step, so a new item may be taken while the last segment still waits.
// Reset puts the sequencer in the idle step and empties the segment register.
`timescale 1ns / 1ps
`default_nettype none

module morse_code_keyer
    import mck_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mck_in_if.sink     item,
    mck_out_if.source  seg
);

    ctrl_t ctrl;
    stat_t stat;
    logic  fire;

    // item channel is open during the idle step only
    assign item.ready = ctrl.take_in;

    // sequencer
    mck_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .fire     (fire)
    );

    // datapath
    mck_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .fire      (fire),
        .opcode    (item.opcode),
        .char_code (item.char_code),
        .out_ready (seg.ready),
        .stat      (stat),
        .out_valid (seg.valid),
        .out_level (seg.level),
        .out_units (seg.units),
        .out_last  (seg.last)
    );

endmodule

`default_nettype wire
